// ===== sv/asc_pkg.sv =====
package asc_pkg;

    localparam int SMP_W      = 12;
    localparam int SUM_W      = 28;
    localparam int SQ_W       = 40;
    localparam int CNT_W      = 17;
    localparam int ADC_NUM_W  = 4;
    localparam int BAD_W      = 5;
    localparam int MEAN_W     = 16;
    localparam int SD_W       = 16;
    localparam int QUOT_W     = 32;
    localparam int DEN_W      = 34;
    localparam int PROD_W     = 57;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [11:0] BASE_LOW_RST  = 12'd200;
    localparam logic [11:0] BASE_HIGH_RST = 12'd350;
    localparam logic [15:0] SD_LOW_RST    = 16'd10;
    localparam logic [15:0] SD_HIGH_RST   = 16'd2560;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_LOW  = 3'd0,
        CFG_BASE_HIGH = 3'd1,
        CFG_SD_LOW    = 3'd2,
        CFG_SD_HIGH   = 3'd3,
        CFG_RESTART   = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [2:0]  channel;
        logic [31:0] raw_word;
        logic        end_of_collection;
    } t_in_item;

    typedef struct packed {
        logic [ADC_NUM_W-1:0] adc_number;
        logic [MEAN_W-1:0]    mean_value;
        logic [SD_W-1:0]      stdev_value;
        logic                 plain_flag;
        logic                 toggling_flag;
        logic                 too_high_flag;
        logic                 too_low_flag;
        logic [3:0]           bad_so_far;
        logic                 restart_request;
        logic                 last_result;
    } t_out_item;

    typedef struct packed {
        logic [11:0] baseline_low_limit;
        logic [11:0] baseline_high_limit;
        logic [15:0] stdev_low_limit;
        logic [15:0] stdev_high_limit;
        logic        restart_enable;
    } t_cfg;

    typedef struct packed {
        logic [ADC_NUM_W-1:0] adc;
        logic                 release_snap;
    } t_snap_req;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [CNT_W-1:0] cnt;
    } t_snap_rd;

endpackage

// ===== sv/asc_front.sv =====
module asc_front
    import asc_pkg::*;
#(
    parameter int NUM_CHANNELS = 5,
    parameter int MAX_SAMPLES  = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_item  i_item,
    output logic      o_full,
    input  t_snap_req i_req,
    output t_snap_rd  o_rd,
    output logic      o_snap_valid
);

    localparam int NUM_ADCS = 2 * NUM_CHANNELS;

    logic [SUM_W-1:0] r_sum [NUM_ADCS];
    logic [SQ_W-1:0]  r_sq  [NUM_ADCS];
    logic [CNT_W-1:0] r_cnt [NUM_CHANNELS];
    logic [SUM_W-1:0] n_sum [NUM_ADCS];
    logic [SQ_W-1:0]  n_sq  [NUM_ADCS];
    logic [CNT_W-1:0] n_cnt [NUM_CHANNELS];
    logic [SUM_W-1:0] r_snap_sum [NUM_ADCS];
    logic [SQ_W-1:0]  r_snap_sq  [NUM_ADCS];
    logic [CNT_W-1:0] r_snap_cnt [NUM_CHANNELS];
    logic             r_snap_valid;

    logic             accept;
    logic [SMP_W-1:0] s_lo;
    logic [SMP_W-1:0] s_hi;
    logic [2*SMP_W-1:0] sq_lo;
    logic [2*SMP_W-1:0] sq_hi;

    assign accept = i_push && !r_snap_valid;
    assign s_lo   = i_item.raw_word[11:0];
    assign s_hi   = i_item.raw_word[27:16];
    assign sq_lo  = s_lo * s_lo;
    assign sq_hi  = s_hi * s_hi;

    always_comb begin
        logic take;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            take = accept && (int'(i_item.channel) == c) && (r_cnt[c] < CNT_W'(MAX_SAMPLES));
            n_cnt[c]       = take ? r_cnt[c] + CNT_W'(1) : r_cnt[c];
            n_sum[2*c]     = take ? r_sum[2*c] + SUM_W'(s_lo) : r_sum[2*c];
            n_sum[2*c+1]   = take ? r_sum[2*c+1] + SUM_W'(s_hi) : r_sum[2*c+1];
            n_sq[2*c]      = take ? r_sq[2*c] + SQ_W'(sq_lo) : r_sq[2*c];
            n_sq[2*c+1]    = take ? r_sq[2*c+1] + SQ_W'(sq_hi) : r_sq[2*c+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ADCS; i++) begin
                r_sum[i] <= '0;
                r_sq[i]  <= '0;
            end
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_cnt[c] <= '0;
            end
            r_snap_valid <= 1'b0;
        end else begin
            if (accept && i_item.end_of_collection) begin
                for (int i = 0; i < NUM_ADCS; i++) begin
                    r_snap_sum[i] <= n_sum[i];
                    r_snap_sq[i]  <= n_sq[i];
                    r_sum[i]      <= '0;
                    r_sq[i]       <= '0;
                end
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    r_snap_cnt[c] <= n_cnt[c];
                    r_cnt[c]      <= '0;
                end
                r_snap_valid <= 1'b1;
            end else if (accept) begin
                for (int i = 0; i < NUM_ADCS; i++) begin
                    r_sum[i] <= n_sum[i];
                    r_sq[i]  <= n_sq[i];
                end
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    r_cnt[c] <= n_cnt[c];
                end
            end
            if (i_req.release_snap) begin
                r_snap_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_rd = '0;
        for (int i = 0; i < NUM_ADCS; i++) begin
            if (int'(i_req.adc) == i) begin
                o_rd.sum = r_snap_sum[i];
                o_rd.sq  = r_snap_sq[i];
            end
        end
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (int'(i_req.adc[ADC_NUM_W-1:1]) == c) begin
                o_rd.cnt = r_snap_cnt[c];
            end
        end
    end

    assign o_full       = r_snap_valid;
    assign o_snap_valid = r_snap_valid;

endmodule

// ===== sv/asc_div.sv =====
module asc_div
    import asc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DEN_W-1:0]  i_rem_init,
    input  logic [QUOT_W-1:0] i_low,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(QUOT_W);

    logic [DEN_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_low;
    logic [QUOT_W-1:0] r_quot;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0] shifted;
    logic           ge;

    assign shifted = {r_rem, r_low[QUOT_W-1]};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_start) begin
                r_rem  <= i_rem_init;
                r_low  <= i_low;
                r_den  <= i_den;
                r_step <= '0;
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_rem  <= ge ? DEN_W'(shifted - {1'b0, r_den}) : shifted[DEN_W-1:0];
                r_low  <= {r_low[QUOT_W-2:0], 1'b0};
                r_quot <= {r_quot[QUOT_W-2:0], ge};
                r_step <= r_step + STEP_W'(1);
                r_done <= (r_step == STEP_W'(QUOT_W - 1));
                if (r_step == STEP_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sv/asc_back.sv =====
module asc_back
    import asc_pkg::*;
#(
    parameter int NUM_CHANNELS = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_snap_valid,
    input  t_snap_rd  i_rd,
    output t_snap_req o_req,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_out_item
);

    localparam int NUM_ADCS = 2 * NUM_CHANNELS;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MUL_A, S_MUL_B, S_ADD, S_DIFF,
        S_DIV_MEAN, S_DIV_VAR, S_SQRT, S_EMIT
    } t_state;

    t_state             r_state;
    logic [ADC_NUM_W-1:0] r_k;
    logic [SUM_W-1:0]   r_sum;
    logic [SQ_W-1:0]    r_sq;
    logic [CNT_W-1:0]   r_n;
    logic [PROD_W-1:0]  r_a;
    logic [2*SUM_W-1:0] r_b;
    logic [DEN_W-1:0]   r_nn;
    logic [CNT_W+19:0]  r_p;
    logic [PROD_W-1:0]  r_d;
    logic [MEAN_W-1:0]  r_mean;
    logic [SD_W-1:0]    r_sd;
    logic [BAD_W-1:0]   r_bad;
    logic [QUOT_W-1:0]  r_v;
    logic [QUOT_W-1:0]  r_r;
    logic [QUOT_W-1:0]  r_bit;
    logic [3:0]         r_sq_step;
    t_out_item          r_out;
    logic               r_out_valid;

    logic              div_start;
    logic [DEN_W-1:0]  div_rem;
    logic [QUOT_W-1:0] div_low;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [QUOT_W-1:0] div_quot;
    logic              sat;
    logic [QUOT_W:0]   rb_sum;
    logic              sq_ge;
    logic              f_plain;
    logic              f_tog;
    logic              f_hi;
    logic              f_lo;
    logic [BAD_W-1:0]  n_bad;
    logic              last;
    logic              slot_free;

    assign sat    = r_d >= PROD_W'({r_nn, 12'b0});
    assign rb_sum = {1'b0, r_r} + {1'b0, r_bit};
    assign sq_ge  = {1'b0, r_v} >= rb_sum;

    assign f_plain   = r_sd <= i_cfg.stdev_low_limit;
    assign f_tog     = r_sd >= i_cfg.stdev_high_limit;
    assign f_hi      = r_mean >= {i_cfg.baseline_high_limit, 4'b0};
    assign f_lo      = r_mean <= {i_cfg.baseline_low_limit, 4'b0};
    assign n_bad     = r_bad + BAD_W'(f_plain | f_tog | f_hi | f_lo);
    assign last      = r_k == ADC_NUM_W'(NUM_ADCS - 1);
    assign slot_free = !r_out_valid || pop;

    always_comb begin
        div_start = 1'b0;
        if (r_state == S_DIFF && r_n != '0) begin
            div_start = 1'b1;
        end
        if (r_state == S_DIV_MEAN && div_done && !sat) begin
            div_start = 1'b1;
        end
        if (r_state == S_DIFF) begin
            div_rem = '0;
            div_low = {r_sum, 4'b0};
            div_den = DEN_W'(r_n);
        end else begin
            div_rem = r_d[DEN_W+11:12];
            div_low = {r_d[11:0], 20'b0};
            div_den = r_nn;
        end
    end

    asc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_rem_init (div_rem),
        .i_low      (div_low),
        .i_den      (div_den),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_snap_valid) begin
                        r_k     <= '0;
                        r_bad   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_sum   <= i_rd.sum;
                    r_sq    <= i_rd.sq;
                    r_n     <= i_rd.cnt;
                    r_state <= S_MUL_A;
                end
                S_MUL_A: begin
                    r_a     <= PROD_W'(r_n) * PROD_W'(r_sq[19:0]);
                    r_b     <= r_sum * r_sum;
                    r_nn    <= DEN_W'(r_n) * DEN_W'(r_n);
                    r_state <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_p     <= r_n * r_sq[SQ_W-1:20];
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_a     <= r_a + {r_p, 20'b0};
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_d <= (r_a > PROD_W'(r_b)) ? r_a - PROD_W'(r_b) : '0;
                    if (r_n == '0) begin
                        r_mean  <= '0;
                        r_sd    <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DIV_MEAN;
                    end
                end
                S_DIV_MEAN: begin
                    if (div_done) begin
                        r_mean <= div_quot[MEAN_W-1:0];
                        if (sat) begin
                            r_sd    <= '1;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_DIV_VAR;
                        end
                    end
                end
                S_DIV_VAR: begin
                    if (div_done) begin
                        r_v       <= div_quot;
                        r_r       <= '0;
                        r_bit     <= QUOT_W'(1) << (QUOT_W - 2);
                        r_sq_step <= '0;
                        r_state   <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_ge) begin
                        r_v <= r_v - rb_sum[QUOT_W-1:0];
                        r_r <= (r_r >> 1) + r_bit;
                        r_sd <= SD_W'((r_r >> 1) + r_bit);
                    end else begin
                        r_r <= r_r >> 1;
                        r_sd <= SD_W'(r_r >> 1);
                    end
                    r_bit     <= r_bit >> 2;
                    r_sq_step <= r_sq_step + 4'd1;
                    if (r_sq_step == 4'd15) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out.adc_number      <= r_k;
                        r_out.mean_value      <= r_mean;
                        r_out.stdev_value     <= r_sd;
                        r_out.plain_flag      <= f_plain;
                        r_out.toggling_flag   <= f_tog;
                        r_out.too_high_flag   <= f_hi;
                        r_out.too_low_flag    <= f_lo;
                        r_out.bad_so_far      <= n_bad[3:0];
                        r_out.restart_request <= last && (n_bad != '0)
                                                 && i_cfg.restart_enable;
                        r_out.last_result     <= last;
                        r_bad                 <= n_bad;
                        if (last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + ADC_NUM_W'(1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_req.adc          = r_k;
    assign o_req.release_snap = (r_state == S_EMIT) && slot_free && last;
    assign empty              = !r_out_valid;
    assign o_out_item         = r_out;

endmodule

// ===== sv/adc_stuck_statistics_checker.sv =====
// Per-ADC mean and standard deviation check. Sample words are taken one per
// cycle while no evaluation is pending; the item carrying the end mark copies
// all sums into a snapshot and clears the running sums. The snapshot is then
// evaluated one ADC after another: multiply and subtract states (MUL_A, MUL_B,
// ADD, DIFF), two 32-step shift-subtract divisions (mean, then variance) on
// one shared divider, and a 16-step square root; an empty channel or a
// saturated variance skips the later steps. While a snapshot is evaluated,
// full stays high until the last result enters the output register, which
// can wait on pop. Results leave through a one-entry output register.
module adc_stuck_statistics_checker
    import asc_pkg::*;
#(
    parameter int MAX_SAMPLES  = 65536,
    parameter int NUM_CHANNELS = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  t_in_item              i_in_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_snap_req req;
    t_snap_rd  rd;
    logic      snap_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.baseline_low_limit  <= BASE_LOW_RST;
            r_cfg.baseline_high_limit <= BASE_HIGH_RST;
            r_cfg.stdev_low_limit     <= SD_LOW_RST;
            r_cfg.stdev_high_limit    <= SD_HIGH_RST;
            r_cfg.restart_enable      <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_BASE_LOW:  r_cfg.baseline_low_limit  <= i_cfg_data[11:0];
                CFG_BASE_HIGH: r_cfg.baseline_high_limit <= i_cfg_data[11:0];
                CFG_SD_LOW:    r_cfg.stdev_low_limit     <= i_cfg_data;
                CFG_SD_HIGH:   r_cfg.stdev_high_limit    <= i_cfg_data;
                CFG_RESTART:   r_cfg.restart_enable      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    asc_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_SAMPLES  (MAX_SAMPLES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (i_in_item),
        .o_full       (full),
        .i_req        (req),
        .o_rd         (rd),
        .o_snap_valid (snap_valid)
    );

    asc_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_snap_valid (snap_valid),
        .i_rd         (rd),
        .o_req        (req),
        .pop          (pop),
        .empty        (empty),
        .o_out_item   (o_out_item)
    );

endmodule

// ===== sv/asc_checker.sv =====
module asc_checker
    import asc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  push,
    input t_in_item              i_in_item,
    input logic                  full,
    input logic                  pop,
    input logic                  empty,
    input t_out_item             o_out_item,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue state not cleared by reset");

    a_restart_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !o_out_item.restart_request || o_out_item.last_result)
        else $error("restart request away from last beat");

    a_bad_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> {1'b0, o_out_item.bad_so_far} <= {1'b0, o_out_item.adc_number} + 5'd1)
        else $error("bad count exceeds ADCs seen");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_item))
        else $error("stalled beat changed");

endmodule

bind adc_stuck_statistics_checker asc_checker u_asc_checker (.*);
